// ===== rtl/core/http_header_line_checker_assert.svh =====
// ----------------------------------------------------------------------------
// http_header_line_checker_assert.svh
// Assertion macros for the header line checker, used by hhlc_line_fsm.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LINE_CHECKER_ASSERT_SVH
`define HTTP_HEADER_LINE_CHECKER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define HHLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define HHLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hhlc_pkg.sv =====
// ----------------------------------------------------------------------------
// hhlc_pkg
// Types, codes and byte classes for the HTTP header line checker.
// ----------------------------------------------------------------------------
package hhlc_pkg;

    localparam int COUNT_W = 12;
    localparam logic [COUNT_W-1:0] MAX_VALUE_LEN = 12'd4095;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CTL_MAX = 8'h1F;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    typedef enum logic [9:0] {
        LS_KEY_START  = 10'b00_0000_0001,
        LS_IN_KEY     = 10'b00_0000_0010,
        LS_AFTER_KEY  = 10'b00_0000_0100,
        LS_PRE_VALUE  = 10'b00_0000_1000,
        LS_IN_VALUE   = 10'b00_0001_0000,
        LS_VALUE_CR   = 10'b00_0010_0000,
        LS_BLANK_CR   = 10'b00_0100_0000,
        LS_ACCEPTED   = 10'b00_1000_0000,
        LS_REJECTED   = 10'b01_0000_0000,
        LS_INCOMPLETE = 10'b10_0000_0000
    } t_line_state;

    typedef enum logic [2:0] {
        KIND_SKIP  = 3'd0,
        KIND_KEY   = 3'd1,
        KIND_VALUE = 3'd2,
        KIND_LINE  = 3'd3,
        KIND_BLANK = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        STAT_PARSING    = 2'd0,
        STAT_ACCEPTED   = 2'd1,
        STAT_ERROR      = 2'd2,
        STAT_INCOMPLETE = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_block;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        t_kind              byte_kind;
        logic [COUNT_W-1:0] value_length;
        t_status            parse_status;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
    endfunction

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CHAR_CTL_MAX) || (c == CHAR_DEL);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == 8'h28) || (c == 8'h29) || (c == 8'h3C) || (c == 8'h3E) ||
               (c == 8'h40) || (c == 8'h2C) || (c == 8'h3B) || (c == CHAR_COLON) ||
               (c == 8'h5C) || (c == 8'h22) || (c == 8'h2F) || (c == 8'h5B) ||
               (c == 8'h5D) || (c == 8'h3F) || (c == 8'h3D) || (c == 8'h7B) ||
               (c == 8'h7D) || (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

endpackage

// ===== rtl/core/hhlc_in_stage.sv =====
// ----------------------------------------------------------------------------
// hhlc_in_stage
// Input register: holds one accepted word until the line logic takes it.
// ----------------------------------------------------------------------------
module hhlc_in_stage
    import hhlc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    output logic     o_valid,
    output t_in_word o_word,
    input  logic     i_take
);

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

// ===== rtl/core/hhlc_line_fsm.sv =====
// ----------------------------------------------------------------------------
// hhlc_line_fsm
// Line grammar state, value counters and per-byte result.
// ----------------------------------------------------------------------------
module hhlc_line_fsm
    import hhlc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_word i_word,
    output t_result  o_result
);

`include "http_header_line_checker_assert.svh"

    t_line_state        r_state, n_state;
    logic [COUNT_W-1:0] r_vcount, n_vcount;
    logic [COUNT_W-1:0] r_tcount, n_tcount;

    t_line_state        cur_state;
    logic [COUNT_W-1:0] cur_vcount;
    logic [COUNT_W-1:0] cur_tcount;
    logic [COUNT_W-1:0] inc_vcount;
    logic [7:0]         c;
    logic               c_ws;
    t_line_state        step_state;
    t_kind              kind;
    logic [COUNT_W-1:0] vlen;
    t_status            status;

    assign c          = i_word.data_byte;
    assign c_ws       = is_ws(c);
    assign cur_state  = i_word.start_block ? LS_KEY_START : r_state;
    assign cur_vcount = i_word.start_block ? '0 : r_vcount;
    assign cur_tcount = i_word.start_block ? '0 : r_tcount;
    assign inc_vcount = (cur_vcount < MAX_VALUE_LEN) ? cur_vcount + 1'b1 : cur_vcount;

    always_comb begin
        step_state = cur_state;
        n_vcount   = cur_vcount;
        n_tcount   = cur_tcount;
        kind       = KIND_SKIP;
        vlen       = '0;
        unique case (cur_state)
            LS_KEY_START: begin
                if (c == CHAR_CR) begin
                    step_state = LS_BLANK_CR;
                end else if (is_ctl(c)) begin
                    step_state = LS_REJECTED;
                end else if (!c_ws) begin
                    if (is_sep(c)) begin
                        step_state = LS_REJECTED;
                    end else begin
                        step_state = LS_IN_KEY;
                        kind       = KIND_KEY;
                    end
                end
            end
            LS_IN_KEY: begin
                if (c_ws) begin
                    step_state = LS_AFTER_KEY;
                end else if (c == CHAR_COLON) begin
                    step_state = LS_PRE_VALUE;
                end else if (is_ctl(c) || is_sep(c)) begin
                    step_state = LS_REJECTED;
                end else begin
                    kind = KIND_KEY;
                end
            end
            LS_AFTER_KEY: begin
                if (c == CHAR_COLON) begin
                    step_state = LS_PRE_VALUE;
                end else if (!c_ws) begin
                    step_state = LS_REJECTED;
                end
            end
            LS_PRE_VALUE: begin
                if (!c_ws) begin
                    step_state = LS_IN_VALUE;
                    n_vcount   = COUNT_W'(1);
                    n_tcount   = COUNT_W'(1);
                    kind       = KIND_VALUE;
                end
            end
            LS_IN_VALUE: begin
                if (c == CHAR_CR) begin
                    step_state = LS_VALUE_CR;
                end else begin
                    n_vcount = inc_vcount;
                    if (!c_ws) begin
                        n_tcount = inc_vcount;
                    end
                    kind = KIND_VALUE;
                end
            end
            LS_VALUE_CR: begin
                if (c == CHAR_LF) begin
                    kind       = KIND_LINE;
                    vlen       = cur_tcount;
                    n_vcount   = '0;
                    n_tcount   = '0;
                    step_state = LS_KEY_START;
                end else begin
                    step_state = LS_REJECTED;
                end
            end
            LS_BLANK_CR: begin
                if (c == CHAR_LF) begin
                    kind       = KIND_BLANK;
                    step_state = LS_ACCEPTED;
                end else begin
                    step_state = LS_REJECTED;
                end
            end
            default: begin
            end
        endcase

        if (i_word.last_byte && (step_state != LS_ACCEPTED) &&
            (step_state != LS_REJECTED)) begin
            n_state = LS_INCOMPLETE;
        end else begin
            n_state = step_state;
        end

        priority case (n_state)
            LS_ACCEPTED:   status = STAT_ACCEPTED;
            LS_REJECTED:   status = STAT_ERROR;
            LS_INCOMPLETE: status = STAT_INCOMPLETE;
            default:       status = STAT_PARSING;
        endcase
    end

    assign o_result.byte_kind    = kind;
    assign o_result.value_length = vlen;
    assign o_result.parse_status = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= LS_KEY_START;
            r_vcount <= '0;
            r_tcount <= '0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_vcount <= n_vcount;
            r_tcount <= n_tcount;
        end
    end

    `HHLC_ASSERT_NOW(a_trim_le_count, 1'b1, r_tcount <= r_vcount,
        "trimmed count exceeds value count")
    `HHLC_ASSERT_NOW(a_blank_accepts, i_step && (kind == KIND_BLANK),
        status == STAT_ACCEPTED, "blank line end without accept")
    `HHLC_ASSERT_NOW(a_len_only_on_line, i_step && (kind != KIND_LINE), vlen == '0,
        "value length outside finished line")
    `HHLC_ASSERT_NEXT(a_ended_holds,
        i_step && !i_word.start_block &&
        ((r_state == LS_ACCEPTED) || (r_state == LS_REJECTED)),
        $stable(r_state), "ended block changed state without restart")

endmodule

// ===== rtl/core/hhlc_out_stage.sv =====
// ----------------------------------------------------------------------------
// hhlc_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module hhlc_out_stage
    import hhlc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/core/http_header_line_checker.sv =====
// ----------------------------------------------------------------------------
// http_header_line_checker
// Byte-wide HTTP header block checker: one result word per input byte.
//
// The slave channel takes one header byte per word (s_axis_tdata), with
// s_axis_tuser restarting the block at this byte and s_axis_tlast marking the
// final byte. The master channel returns one word per byte: the byte's role,
// the trimmed value length when a line finishes, and the block status.
// A byte moves from the input register through the line logic into the result
// register, which loads it once free, and the result word is then offered.
// One word per cycle is sustained while the receiver holds m_axis_tready high.
// Reset returns the parser to line start and empties both registers.
// While the receiver holds m_axis_tready low, the result word holds, one more
// byte waits in the input register, and then s_axis_tready drops; no word is
// lost or dropped.
// ----------------------------------------------------------------------------
module http_header_line_checker
    import hhlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_block
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [2:0] byte_kind, [14:3] value_length,
                                        // [16:15] parse_status, [23:17] zero
);

    t_in_word in_word;
    t_in_word st_word;
    logic     st_valid;
    logic     out_free;
    logic     step;
    t_result  step_result;
    t_result  out_result;

    assign in_word.data_byte   = s_axis_tdata;
    assign in_word.start_block = s_axis_tuser;
    assign in_word.last_byte   = s_axis_tlast;
    assign step                = st_valid && out_free;

    hhlc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (in_word),
        .o_valid (st_valid),
        .o_word  (st_word),
        .i_take  (step)
    );

    hhlc_line_fsm u_line_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (st_word),
        .o_result (step_result)
    );

    hhlc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {7'd0, out_result.parse_status, out_result.value_length,
                           out_result.byte_kind};

endmodule
